// ===== hdl/pcc_pkg.sv =====
// shared types, constants and the digit decoder for the crossing controller
// no dependencies
package pcc_pkg;

  // fixed field widths
  localparam int MIN_DIST_W   = 12;
  localparam int CROSS_TIME_W = 14;
  localparam int ANGLE_W      = 8;
  localparam int NOW_W        = 32;
  localparam int SEG_W        = 7;
  localparam int DIGIT_W      = 4;
  localparam int TIMER_W      = 34;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 14;

  // parameter defaults
  localparam int WINDOW_LEN_DEF = 10;
  localparam int DIST_BITS_DEF  = 12;

  // reset values
  localparam int DIST_RESET       = 100;
  localparam int MIN_DIST_RESET   = 25;
  localparam int CROSS_TIME_RESET = 10 * 1000 - 1;
  localparam int GATE_UP_RESET    = 150;
  localparam int GATE_DOWN_RESET  = 50;

  // countdown digit
  localparam int DIGIT_MS     = 1000;
  localparam int MAX_DIGIT    = 9;
  localparam int DIGIT_SAT_MS = (MAX_DIGIT + 1) * DIGIT_MS;

  localparam logic [SEG_W-1:0] SEG_BLANK = 7'b0000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_DIST   = 2'd0,
    CFG_CROSS_TIME = 2'd1,
    CFG_GATE_UP    = 2'd2,
    CFG_GATE_DOWN  = 2'd3
  } cfg_idx_e;

  // bit0 = segment a .. bit6 = segment g
  function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] digit);
    logic [SEG_W-1:0] seg;
    case (digit)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h6F;
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

endpackage

// ===== hdl/pedestrian_crossing_controller_top.sv =====
// pedestrian crossing controller: one control tick per word, one result word per tick
// depends on pcc_pkg
//
// path: input register, then result register; a stalled result word holds
// throughput: one word per cycle; input stalls only while a full result register is stalled
// reset (async, active low): distance window all 100, sum 100 * WINDOW_LEN, no request,
//   red on, buzzer off, not dimmed, crossing start at minus 9999, registers at defaults
module pedestrian_crossing_controller_top #(
  parameter int WINDOW_LEN = pcc_pkg::WINDOW_LEN_DEF,
  parameter int DIST_BITS  = pcc_pkg::DIST_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [pcc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pcc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // tick channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              button_pressed_i,
  input  logic [DIST_BITS-1:0]              distance_cm_i,
  input  logic [pcc_pkg::NOW_W-1:0]         now_ms_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              red_on_o,
  output logic                              green_on_o,
  output logic                              yellow_on_o,
  output logic                              buzzer_on_o,
  output logic [pcc_pkg::ANGLE_W-1:0]       gate_angle_o,
  output logic [pcc_pkg::SEG_W-1:0]         segment_bits_o,
  output logic                              crossing_active_o
);

  localparam int TW    = pcc_pkg::TIMER_W;
  localparam int CTW   = pcc_pkg::CROSS_TIME_W;
  // running sum must hold a full window of maximum samples
  localparam int SUM_W = $clog2(WINDOW_LEN * ((2 ** DIST_BITS) - 1) + 1);
  localparam int THR_W = $clog2(WINDOW_LEN * ((2 ** pcc_pkg::MIN_DIST_W) - 1) + 1);
  localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;

  // ---------------------------------------------------------------- config registers
  logic [pcc_pkg::MIN_DIST_W-1:0] min_dist_q;
  logic [CTW-1:0]                 cross_time_q;
  logic [pcc_pkg::ANGLE_W-1:0]    gate_up_q;
  logic [pcc_pkg::ANGLE_W-1:0]    gate_down_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dist_q   <= pcc_pkg::MIN_DIST_W'(pcc_pkg::MIN_DIST_RESET);
      cross_time_q <= CTW'(pcc_pkg::CROSS_TIME_RESET);
      gate_up_q    <= pcc_pkg::ANGLE_W'(pcc_pkg::GATE_UP_RESET);
      gate_down_q  <= pcc_pkg::ANGLE_W'(pcc_pkg::GATE_DOWN_RESET);
    end else if (cfg_we_i) begin
      case (pcc_pkg::cfg_idx_e'(cfg_idx_i))
        pcc_pkg::CFG_MIN_DIST:   min_dist_q   <= cfg_data_i[pcc_pkg::MIN_DIST_W-1:0];
        pcc_pkg::CFG_CROSS_TIME: cross_time_q <= cfg_data_i[CTW-1:0];
        pcc_pkg::CFG_GATE_UP:    gate_up_q    <= cfg_data_i[pcc_pkg::ANGLE_W-1:0];
        pcc_pkg::CFG_GATE_DOWN:  gate_down_q  <= cfg_data_i[pcc_pkg::ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake
  logic s1_valid_q;
  logic out_valid_q;
  logic out_free;   // result register empty or being taken this cycle
  logic advance;    // input register word moves into the result register
  logic in_acc;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      out_valid_q <= advance || (out_valid_q && out_stall_i);
    end
  end

  // ---------------------------------------------------------------- input register
  logic                      s1_button_q;
  logic [DIST_BITS-1:0]      s1_dist_q;
  logic [pcc_pkg::NOW_W-1:0] s1_now_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_button_q <= button_pressed_i;
      s1_dist_q   <= distance_cm_i;
      s1_now_q    <= now_ms_i;
    end
  end

  // ---------------------------------------------------------------- controller state
  logic [DIST_BITS-1:0]  win_q [WINDOW_LEN];   // shift line, newest at index 0
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic                  pend_q, pend_d;
  logic                  red_q, red_d;
  logic                  buzz_q, buzz_d;
  logic                  dim_q, dim_d;
  logic signed [TW-1:0]  cs_q, cs_d;            // crossing start time in ms

  // ---------------------------------------------------------------- tick logic
  logic                      req;
  logic [CMP_W-1:0]          thresh;
  logic                      path_clear;
  logic signed [TW-1:0]      ct_s, now_s, neg_ct, timer_raw, timer_c;
  logic                      active;
  logic                      at_clamp;
  logic [CTW-1:0]            t_low;
  logic [pcc_pkg::DIGIT_W-1:0] digit;

  // window sum never drops below the oldest entry, so the modular add/sub is exact
  assign sum_d      = sum_q - SUM_W'(win_q[WINDOW_LEN-1]) + SUM_W'(s1_dist_q);
  // average >= min_distance, scaled by the window length
  assign thresh     = CMP_W'(WINDOW_LEN) * CMP_W'(min_dist_q);
  assign path_clear = CMP_W'(sum_d) >= thresh;

  assign req       = pend_q || s1_button_q;
  assign ct_s      = $signed({{(TW-CTW){1'b0}}, cross_time_q});
  assign now_s     = $signed({{(TW-pcc_pkg::NOW_W){1'b0}}, s1_now_q});
  assign neg_ct    = -ct_s;
  // countdown from the previous start; a start taken this tick shows on the next
  assign timer_raw = cs_q + ct_s - now_s;
  assign timer_c   = (timer_raw < neg_ct) ? neg_ct : timer_raw;
  assign active    = !timer_c[TW-1];
  assign at_clamp  = (timer_c == neg_ct);

  // seconds digit, saturated at nine
  assign t_low = timer_c[CTW-1:0];
  always_comb begin
    digit = '0;
    if (timer_c >= $signed(TW'(pcc_pkg::DIGIT_SAT_MS))) begin
      digit = pcc_pkg::DIGIT_W'(pcc_pkg::MAX_DIGIT);
    end else begin
      for (int k = 1; k <= pcc_pkg::MAX_DIGIT; k++) begin
        if (t_low >= CTW'(k * pcc_pkg::DIGIT_MS)) begin
          digit = pcc_pkg::DIGIT_W'(k);
        end
      end
    end
  end

  // request / idle / crossing rules
  always_comb begin
    pend_d = req;
    red_d  = red_q;
    buzz_d = buzz_q;
    dim_d  = dim_q;
    cs_d   = cs_q;
    if (req) begin
      dim_d = 1'b0;
      if (path_clear) begin
        cs_d   = now_s;
        red_d  = 1'b0;
        pend_d = 1'b0;
      end else begin
        red_d  = 1'b1;
        buzz_d = 1'b1;
      end
    end else if (!active) begin
      buzz_d = 1'b0;
      red_d  = 1'b1;
      if (at_clamp) begin
        dim_d = 1'b1;   // idle at the clamp dims both lights
      end
    end
    if (active) begin
      buzz_d = !path_clear;
      red_d  = !path_clear;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_q[i] <= DIST_BITS'(pcc_pkg::DIST_RESET);
      end
      sum_q  <= SUM_W'(pcc_pkg::DIST_RESET * WINDOW_LEN);
      pend_q <= 1'b0;
      red_q  <= 1'b1;
      buzz_q <= 1'b0;
      dim_q  <= 1'b0;
      cs_q   <= -$signed(TW'(pcc_pkg::CROSS_TIME_RESET));
    end else if (advance) begin
      win_q[0] <= s1_dist_q;
      for (int i = 1; i < WINDOW_LEN; i++) begin
        win_q[i] <= win_q[i-1];
      end
      sum_q  <= sum_d;
      pend_q <= pend_d;
      red_q  <= red_d;
      buzz_q <= buzz_d;
      dim_q  <= dim_d;
      cs_q   <= cs_d;
    end
  end

  // ---------------------------------------------------------------- result register
  logic                         red_on_q, green_on_q, yellow_on_q, buzzer_on_q, active_q;
  logic [pcc_pkg::ANGLE_W-1:0]  gate_angle_q;
  logic [pcc_pkg::SEG_W-1:0]    segment_bits_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      red_on_q       <= !dim_d && red_d;
      green_on_q     <= !dim_d && !red_d;
      yellow_on_q    <= active;
      buzzer_on_q    <= buzz_d;
      gate_angle_q   <= active ? gate_down_q : gate_up_q;
      segment_bits_q <= active ? pcc_pkg::seg_of(digit) : pcc_pkg::SEG_BLANK;
      active_q       <= active;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign red_on_o          = red_on_q;
  assign green_on_o        = green_on_q;
  assign yellow_on_o       = yellow_on_q;
  assign buzzer_on_o       = buzzer_on_q;
  assign gate_angle_o      = gate_angle_q;
  assign segment_bits_o    = segment_bits_q;
  assign crossing_active_o = active_q;

endmodule

// ===== hdl/pcc_checker.sv =====
// port-level checks for the crossing controller, bound to the top level
// depends on pcc_pkg and pedestrian_crossing_controller_top
module pcc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          red_on_o,
  input logic                          green_on_o,
  input logic                          yellow_on_o,
  input logic [pcc_pkg::SEG_W-1:0]     segment_bits_o,
  input logic                          crossing_active_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(segment_bits_o)
      && $stable(crossing_active_o) && $stable(red_on_o) && $stable(green_on_o))
    else $error("stalled result word changed");

  // a new result word follows an accepted tick through the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result word without an accepted tick");

  // red and green are never driven together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(red_on_o && green_on_o))
    else $error("red and green both on");

  // yellow and the digit follow the crossing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (yellow_on_o == crossing_active_o)
      && (crossing_active_o || (segment_bits_o == pcc_pkg::SEG_BLANK)))
    else $error("yellow or digit disagrees with crossing state");

endmodule

bind pedestrian_crossing_controller_top pcc_checker u_pcc_checker (.*);

// ===== sim/pedestrian_crossing_controller_top_tb.sv =====
// self-checking testbench for pedestrian_crossing_controller_top: control ticks in, light words out
// predicts every result word with its own model of window, request and countdown state
// depends on pcc_pkg and the controller rtl
module pedestrian_crossing_controller_top_tb;

  localparam int WIN_LEN     = pcc_pkg::WINDOW_LEN_DEF;
  localparam int DIST_W      = pcc_pkg::DIST_BITS_DEF;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE_CYC  = 4;
  localparam int IDLE_PCT    = 18;
  localparam int MAX_REPORTS = 100;

  // one result word as the block drives it
  typedef struct packed {
    logic                         red;
    logic                         green;
    logic                         yellow;
    logic                         buzzer;
    logic [pcc_pkg::ANGLE_W-1:0]  gate;
    logic [pcc_pkg::SEG_W-1:0]    seg;
    logic                         active;
  } panel_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // block inputs, all known from time zero
  logic                           cfg_we_i         = 1'b0;
  logic [pcc_pkg::CFG_IDX_W-1:0]  cfg_idx_i        = '0;
  logic [pcc_pkg::CFG_DATA_W-1:0] cfg_data_i       = '0;
  logic                           in_valid_i       = 1'b0;
  logic                           button_pressed_i = 1'b0;
  logic [DIST_W-1:0]              distance_cm_i    = '0;
  logic [pcc_pkg::NOW_W-1:0]      now_ms_i         = '0;
  logic                           out_stall_i      = 1'b0;

  // block outputs
  logic                           in_stall_o;
  logic                           out_valid_o;
  logic                           red_on_o;
  logic                           green_on_o;
  logic                           yellow_on_o;
  logic                           buzzer_on_o;
  logic [pcc_pkg::ANGLE_W-1:0]    gate_angle_o;
  logic [pcc_pkg::SEG_W-1:0]      segment_bits_o;
  logic                           crossing_active_o;

  pedestrian_crossing_controller_top DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .button_pressed_i  (button_pressed_i),
    .distance_cm_i     (distance_cm_i),
    .now_ms_i          (now_ms_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .red_on_o          (red_on_o),
    .green_on_o        (green_on_o),
    .yellow_on_o       (yellow_on_o),
    .buzzer_on_o       (buzzer_on_o),
    .gate_angle_o      (gate_angle_o),
    .segment_bits_o    (segment_bits_o),
    .crossing_active_o (crossing_active_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // controller model: register copies and tick state
  // ---------------------------------------------------------------------------
  logic [pcc_pkg::MIN_DIST_W-1:0]   cfg_min_dist;
  logic [pcc_pkg::CROSS_TIME_W-1:0] cfg_cross_ms;
  logic [pcc_pkg::ANGLE_W-1:0]      cfg_gate_up;
  logic [pcc_pkg::ANGLE_W-1:0]      cfg_gate_down;

  logic [DIST_W-1:0] dist_window [WIN_LEN];
  int unsigned       dist_sum;
  bit                req_pending;
  bit                red_lit;
  bit                buzz_lit;
  bit                dimmed;
  longint            cross_start_ms;

  // light words still owed by the block, oldest first
  panel_t expected_panels [$];

  // run statistics
  int mismatches        = 0;
  int ticks_sent        = 0;
  int words_checked     = 0;
  int words_crossing    = 0;
  int crossings_started = 0;
  int requests_blocked  = 0;
  int settings_used     = 0;

  // sender and receiver idling controls
  bit   tx_idle_en = 1'b1;
  logic rx_idle_en = 1'b1;
  logic hold_go    = 1'b0;
  logic hold_seen  = 1'b0;
  int   hold_left  = 0;

  // traffic generator state, carried across phases
  logic [pcc_pkg::NOW_W-1:0] now_cur   = '0;
  bit                        path_open = 1'b1;

  task automatic reset_model();
    cfg_min_dist  = pcc_pkg::MIN_DIST_W'(pcc_pkg::MIN_DIST_RESET);
    cfg_cross_ms  = pcc_pkg::CROSS_TIME_W'(pcc_pkg::CROSS_TIME_RESET);
    cfg_gate_up   = pcc_pkg::ANGLE_W'(pcc_pkg::GATE_UP_RESET);
    cfg_gate_down = pcc_pkg::ANGLE_W'(pcc_pkg::GATE_DOWN_RESET);
    for (int i = 0; i < WIN_LEN; i++) dist_window[i] = DIST_W'(pcc_pkg::DIST_RESET);
    dist_sum       = pcc_pkg::DIST_RESET * WIN_LEN;
    req_pending    = 1'b0;
    red_lit        = 1'b1;
    buzz_lit       = 1'b0;
    dimmed         = 1'b0;
    cross_start_ms = -longint'(pcc_pkg::CROSS_TIME_RESET);
  endtask

  // one control tick: shift the window, run the countdown, decide the lights
  function automatic panel_t predict_tick(bit btn, logic [DIST_W-1:0] dist_cm,
                                          logic [pcc_pkg::NOW_W-1:0] now);
    longint ct;
    longint now_l;
    longint countdown;
    longint digit;
    bit     clear_path;
    bit     crossing;
    panel_t p;
    ct    = longint'(cfg_cross_ms);
    now_l = longint'(now);
    if (btn) req_pending = 1'b1;

    dist_sum = dist_sum - dist_window[WIN_LEN-1] + dist_cm;
    for (int i = WIN_LEN - 1; i > 0; i--) dist_window[i] = dist_window[i-1];
    dist_window[0] = dist_cm;
    // exact form of average >= threshold
    clear_path = dist_sum >= WIN_LEN * cfg_min_dist;

    // countdown uses the start time from before this tick
    countdown = cross_start_ms + ct - now_l;
    if (countdown < -ct) countdown = -ct;
    crossing = countdown >= 0;

    if (req_pending) begin
      dimmed = 1'b0;
      if (clear_path) begin
        cross_start_ms = now_l;
        red_lit        = 1'b0;
        req_pending    = 1'b0;
        crossings_started++;
      end else begin
        red_lit  = 1'b1;
        buzz_lit = 1'b1;
        requests_blocked++;
      end
    end else if (!crossing) begin
      buzz_lit = 1'b0;
      red_lit  = 1'b1;
      if (countdown == -ct) dimmed = 1'b1;
    end

    p.seg = pcc_pkg::SEG_BLANK;
    if (crossing) begin
      buzz_lit = !clear_path;
      red_lit  = !clear_path;
      digit    = countdown / pcc_pkg::DIGIT_MS;
      if (digit > pcc_pkg::MAX_DIGIT) digit = pcc_pkg::MAX_DIGIT;
      case (digit)
        0: p.seg = 7'h3F;
        1: p.seg = 7'h06;
        2: p.seg = 7'h5B;
        3: p.seg = 7'h4F;
        4: p.seg = 7'h66;
        5: p.seg = 7'h6D;
        6: p.seg = 7'h7D;
        7: p.seg = 7'h07;
        8: p.seg = 7'h7F;
        default: p.seg = 7'h6F;
      endcase
    end

    p.red    = !dimmed && red_lit;
    p.green  = !dimmed && !red_lit;
    p.yellow = crossing;
    p.buzzer = buzz_lit;
    p.gate   = crossing ? cfg_gate_down : cfg_gate_up;
    p.active = crossing;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: receiver stalls and the checker
  // ---------------------------------------------------------------------------

  // random stalls, plus a long hold-off whenever hold_go toggles
  always @(posedge clk_i) begin
    if (hold_go != hold_seen) begin
      hold_seen = hold_go;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= rx_idle_en && ($urandom_range(99) < IDLE_PCT);
    end
  end

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // every accepted word is compared against the oldest prediction
  always @(posedge clk_i) begin : check_words
    panel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_panels.size() == 0) begin
        mismatches++;
        $display("%0t: result word expected none, actual gate %0d seg %0h", $time,
                 gate_angle_o, segment_bits_o);
      end else begin
        want = expected_panels.pop_front();
        words_checked++;
        if (want.active) words_crossing++;
        check_field("red_on", longint'(want.red), longint'(red_on_o));
        check_field("green_on", longint'(want.green), longint'(green_on_o));
        check_field("yellow_on", longint'(want.yellow), longint'(yellow_on_o));
        check_field("buzzer_on", longint'(want.buzzer), longint'(buzzer_on_o));
        check_field("gate_angle", longint'(want.gate), longint'(gate_angle_o));
        check_field("segment_bits", longint'(want.seg), longint'(segment_bits_o));
        check_field("crossing_active", longint'(want.active), longint'(crossing_active_o));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tick side: driving words and registers
  // ---------------------------------------------------------------------------

  // offer one tick, wait for it to be taken, then log its prediction;
  // valid stays high on return so a following tick goes out back to back
  task automatic send_tick(bit btn, logic [DIST_W-1:0] dist_cm,
                           logic [pcc_pkg::NOW_W-1:0] now);
    if (tx_idle_en) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i       <= 1'b1;
    button_pressed_i <= btn;
    distance_cm_i    <= dist_cm;
    now_ms_i         <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_panels.push_back(predict_tick(btn, dist_cm, now));
    ticks_sent++;
  endtask

  // stop offering and let every owed word come back, then let the lines settle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_panels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(pcc_pkg::cfg_idx_e idx, logic [pcc_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      pcc_pkg::CFG_MIN_DIST:   cfg_min_dist  = data[pcc_pkg::MIN_DIST_W-1:0];
      pcc_pkg::CFG_CROSS_TIME: cfg_cross_ms  = data[pcc_pkg::CROSS_TIME_W-1:0];
      pcc_pkg::CFG_GATE_UP:    cfg_gate_up   = data[pcc_pkg::ANGLE_W-1:0];
      pcc_pkg::CFG_GATE_DOWN:  cfg_gate_down = data[pcc_pkg::ANGLE_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // all four registers; unused upper data bits carry junk that must be dropped
  task automatic configure(int md, int ct, int up, int dn);
    write_reg(pcc_pkg::CFG_MIN_DIST, pcc_pkg::CFG_DATA_W'(md)
              | (pcc_pkg::CFG_DATA_W'($urandom_range(3)) << pcc_pkg::MIN_DIST_W));
    write_reg(pcc_pkg::CFG_CROSS_TIME, pcc_pkg::CFG_DATA_W'(ct));
    write_reg(pcc_pkg::CFG_GATE_UP, pcc_pkg::CFG_DATA_W'(up)
              | (pcc_pkg::CFG_DATA_W'($urandom_range(63)) << pcc_pkg::ANGLE_W));
    write_reg(pcc_pkg::CFG_GATE_DOWN, pcc_pkg::CFG_DATA_W'(dn)
              | (pcc_pkg::CFG_DATA_W'($urandom_range(63)) << pcc_pkg::ANGLE_W));
    settings_used++;
  endtask

  // mostly realistic ticks: time moving forward at a pace tied to the crossing
  // length, obstructed and clear stretches, occasional presses; a few noise ticks
  task automatic run_traffic(int count);
    bit                        btn;
    logic [DIST_W-1:0]         dist_cm;
    logic [pcc_pkg::NOW_W-1:0] now;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 5) begin
        btn     = 1'($urandom_range(1));
        dist_cm = DIST_W'($urandom);
        if ($urandom_range(4) == 0) now_cur = $urandom;
        now = now_cur;
      end else begin
        if ($urandom_range(99) < 6) path_open = !path_open;
        dist_cm = path_open ? DIST_W'($urandom_range((1 << DIST_W) - 1, cfg_min_dist))
                            : DIST_W'($urandom_range(cfg_min_dist, 0));
        btn = $urandom_range(99) < 12;
        // now and then time steps back so the countdown overshoots
        if ($urandom_range(99) < 3) now_cur = now_cur - $urandom_range(3000);
        else now_cur = now_cur + $urandom_range(cfg_cross_ms / 3 + 40, 0);
        now = now_cur;
      end
      send_tick(btn, dist_cm, now);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset defaults: countdown edges, dimming, start timing, blocked request,
  // time running backwards and the extremes of every field
  task automatic test_directed_ticks();
    send_tick(1'b0, 12'd100, 32'd0);        // countdown exactly zero at reset
    send_tick(1'b0, 12'd100, 32'd1);        // just past the end
    send_tick(1'b0, 12'd4095, 32'd9999);    // at the clamp, lights dim
    send_tick(1'b1, 12'd4095, 32'd10000);   // press on a clear path starts a crossing
    send_tick(1'b0, 12'd4095, 32'd10000);   // new start shows one tick later
    // path closes mid crossing, last sample comes with a press that gets refused
    for (int i = 0; i < 10; i++) send_tick(i == 9, 12'd0, 32'd12500 + 100 * i);
    send_tick(1'b0, 12'd4095, 32'd30000);   // held request goes once the path clears
    send_tick(1'b0, 12'd4095, 32'd20000);   // time before the start, digit saturates
    send_tick(1'b0, 12'd4095, 32'hFFFF_FFFF);
    send_tick(1'b1, 12'd4095, 32'hFFFF_FFFF);
    send_tick(1'b0, 12'd4095, 32'hFFFF_FFFF);
    send_tick(1'b0, 12'd4095, 32'd0);       // far behind the latest start
    drain_results();
  endtask

  // register phases: the two extreme settings first, then random ones
  task automatic test_random_traffic();
    int md;
    int ct;
    int up;
    int dn;
    for (int ph = 0; ph < 10; ph++) begin
      drain_results();
      case (ph)
        0: configure(0, 0, 0, 0);
        1: configure((1 << pcc_pkg::MIN_DIST_W) - 1, (1 << pcc_pkg::CROSS_TIME_W) - 1,
                     255, 255);
        default: begin
          case ($urandom_range(3))
            0:       md = 0;
            1:       md = (1 << pcc_pkg::MIN_DIST_W) - 1;
            default: md = $urandom_range(300, 5);
          endcase
          case ($urandom_range(4))
            0:       ct = 0;
            1:       ct = (1 << pcc_pkg::CROSS_TIME_W) - 1;
            2:       ct = pcc_pkg::CROSS_TIME_RESET;
            default: ct = $urandom_range(3000, 200);
          endcase
          up = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(180);
          dn = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(180);
          configure(md, ct, up, dn);
        end
      endcase
      run_traffic(100);
    end
    drain_results();
  endtask

  // receiver holds off while the sender keeps pushing, so the input stalls;
  // afterwards the sender waits for every word before going on
  task automatic test_backpressure();
    configure(40, 1500, 160, 20);
    hold_go    <= !hold_go;
    tx_idle_en  = 1'b0;
    run_traffic(60);
    tx_idle_en  = 1'b1;
    drain_results();
  endtask

  // a long stretch with neither side idling
  task automatic test_back_to_back();
    configure(30, 2500, 90, 0);
    tx_idle_en  = 1'b0;
    rx_idle_en <= 1'b0;
    run_traffic(150);
    tx_idle_en  = 1'b1;
    rx_idle_en <= 1'b1;
    drain_results();
  endtask

  initial begin
    reset_model();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_ticks();
    test_random_traffic();
    test_backpressure();
    test_back_to_back();

    // catch any stray words after the last one owed
    repeat (2 * SETTLE_CYC) @(posedge clk_i);
    $display("%0d ticks sent over %0d register settings: %0d crossings, %0d presses refused",
             ticks_sent, settings_used + 1, crossings_started, requests_blocked);
    $display("%0d result words compared, %0d of them during a crossing",
             words_checked, words_crossing);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog, many times the slowest expected run
  initial begin
    #2_000_000;
    $display("timeout with %0d result words outstanding", expected_panels.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
